// ===== rtl/lbt_pkg.sv =====
// Package for the lane blockage tracker.
// Field widths, register indexes and reset values shared by the interfaces and the top level.
// No dependencies.
package lbt_pkg;

  localparam int MAX_LANES = 8;
  localparam int LANE_W    = 3;   // bits of a lane number
  localparam int CNT_W     = 4;   // bits of lane_count

  localparam int POS_W   = 20;
  localparam int OFF_W   = 16;
  localparam int VEL_W   = 14;
  localparam int LW_W    = 12;
  localparam int SPD_W   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EGO_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd5;

  // reset values
  localparam logic [POS_W-1:0] RST_TRACK_LENGTH = 20'd694555;
  localparam logic [LW_W-1:0]  RST_LANE_WIDTH   = 12'd400;
  localparam logic [CNT_W-1:0] RST_LANE_COUNT   = 4'd3;
  localparam logic [POS_W-1:0] RST_LOOK_AHEAD   = 20'd20000;
  localparam logic [SPD_W-1:0] RST_SPEED_LIMIT  = 14'd2217;

endpackage

// ===== rtl/lbt_if.sv =====
// Handshake channels of the lane blockage tracker: vehicle input, lane result, register write.
// Depends on lbt_pkg.
interface lbt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lbt_pkg::POS_W-1:0]            track_position;
  logic signed [lbt_pkg::OFF_W-1:0]     lateral_offset;
  logic signed [lbt_pkg::VEL_W-1:0]     vel_x;
  logic signed [lbt_pkg::VEL_W-1:0]     vel_y;
  logic                                 last_track;
  modport source (output valid, track_position, lateral_offset, vel_x, vel_y, last_track,
                  input ready);
  modport sink (input valid, track_position, lateral_offset, vel_x, vel_y, last_track,
                output ready);
endinterface

interface lbt_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbt_pkg::LANE_W-1:0]   lane_index;
  logic                         blocked;
  logic [lbt_pkg::POS_W-1:0]    block_distance;
  logic [lbt_pkg::SPD_W-1:0]    exit_speed;
  logic                         last_lane;
  modport source (output valid, lane_index, blocked, block_distance, exit_speed, last_lane,
                  input ready);
  modport sink (input valid, lane_index, blocked, block_distance, exit_speed, last_lane,
                output ready);
endinterface

interface lbt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lbt_pkg::CFG_IDX_W-1:0]     index;
  logic [lbt_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lane_blockage_tracker.sv =====
// Lane blockage tracker top level: registers, serial arithmetic, per-lane store, result output.
// Depends on lbt_pkg and the channels in lbt_if.sv.
// A vehicle transfer passes through square, sum, 20 serial steps and update before the store
// is updated; a new vehicle is taken only back in idle, after the update or after the results.
// The 20 steps are set by the bit-serial remainder of the 20-bit wrapped distance.
// A last vehicle then gives one result per lane, one per cycle while the sink takes them.
// Reset (rst, synchronous) restores register defaults and marks every lane clear.
module lane_blockage_tracker (
  input  logic       clk,
  input  logic       rst,
  lbt_in_if.sink     in_ch,
  lbt_out_if.source  out_ch,
  lbt_cfg_if.sink    cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [4:0] STEPS  = 5'd20;
  localparam logic [4:0] DIV_STEPS = 5'd16;
  localparam logic [4:0] SQ_STEPS  = 5'd14;

  // configuration registers
  logic [lbt_pkg::POS_W-1:0] ego_position, loop_len, look_ahead;
  logic [lbt_pkg::LW_W-1:0]  lane_span;
  logic [lbt_pkg::CNT_W-1:0] lane_count;
  logic [lbt_pkg::SPD_W-1:0] speed_limit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ego_position <= '0;
      loop_len     <= lbt_pkg::RST_TRACK_LENGTH;
      lane_span    <= lbt_pkg::RST_LANE_WIDTH;
      lane_count   <= lbt_pkg::RST_LANE_COUNT;
      look_ahead   <= lbt_pkg::RST_LOOK_AHEAD;
      speed_limit  <= lbt_pkg::RST_SPEED_LIMIT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lbt_pkg::REG_EGO_POSITION: ego_position <= cfg_ch.data;
        lbt_pkg::REG_TRACK_LENGTH: loop_len     <= cfg_ch.data;
        lbt_pkg::REG_LANE_WIDTH:   lane_span    <= cfg_ch.data[lbt_pkg::LW_W-1:0];
        lbt_pkg::REG_LANE_COUNT:   lane_count   <= cfg_ch.data[lbt_pkg::CNT_W-1:0];
        lbt_pkg::REG_LOOK_AHEAD:   look_ahead   <= cfg_ch.data;
        lbt_pkg::REG_SPEED_LIMIT:  speed_limit  <= cfg_ch.data[lbt_pkg::SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lane count, 1..MAX_LANES
  logic [lbt_pkg::CNT_W-1:0] lanes;
  always_comb begin
    if (lane_count == '0) lanes = 4'd1;
    else if (lane_count > 4'(lbt_pkg::MAX_LANES)) lanes = 4'(lbt_pkg::MAX_LANES);
    else lanes = lane_count;
  end

  logic [2:0] state;
  logic [4:0] cnt;

  // captured item
  logic [20:0]               diff;       // signed pos - ego
  logic [lbt_pkg::OFF_W-1:0] off;
  logic signed [lbt_pkg::VEL_W-1:0] vx, vy;
  logic                      last;
  logic [27:0]               px, py;

  // serial units
  logic [19:0] md_a;    // distance magnitude, shifted out MSB first
  logic [19:0] md_r;    // running remainder
  logic [15:0] ld_n;    // offset, shifted out MSB first
  logic [11:0] ld_r;
  logic [15:0] ld_q;
  logic [27:0] sq_rad;
  logic [14:0] sq_rem;
  logic [13:0] sq_root;

  logic        neg;
  logic [19:0] mag;
  assign neg = diff[20];
  assign mag = neg ? 20'(-diff) : diff[19:0];

  // one step of each serial unit
  logic [20:0] md_t;
  logic [12:0] ld_t;
  logic [16:0] sq_t, sq_trial;
  assign md_t     = {md_r, md_a[19]};
  assign ld_t     = {ld_r, ld_n[15]};
  assign sq_t     = {sq_rem, sq_rad[27:26]};
  assign sq_trial = {1'b0, sq_root, 2'b01};

  // per-lane store
  logic [lbt_pkg::POS_W-1:0] near_dist [lbt_pkg::MAX_LANES];
  logic [lbt_pkg::SPD_W-1:0] near_spd  [lbt_pkg::MAX_LANES];
  logic [lbt_pkg::MAX_LANES-1:0] seen;
  logic [lbt_pkg::LANE_W-1:0] k;

  // update-step decisions
  logic [19:0] fwd_dist;
  logic        dist_ok;
  logic [15:0] road;
  logic        on_road;
  logic [lbt_pkg::LANE_W-1:0] lane;
  always_comb begin
    dist_ok = 1'b1;
    if (loop_len == '0) begin
      dist_ok  = !neg;
      fwd_dist = mag;
    end else if (neg) begin
      fwd_dist = (md_r == '0) ? '0 : loop_len - md_r;
    end else if (mag > loop_len) begin
      fwd_dist = (md_r == '0) ? loop_len : md_r;
    end else begin
      fwd_dist = mag;
    end
    road    = 16'(lanes) * 16'(lane_span);
    on_road = !off[15] && (off <= road);
    if (lane_span == '0) lane = '0;
    else if (ld_q >= 16'(lanes)) lane = 3'(lanes - 4'd1);
    else lane = ld_q[2:0];
  end

  assign in_ch.ready = (state == S_IDLE);

  logic out_free, last_k;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign last_k   = (4'(k) + 4'd1 == lanes);

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
      seen  <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) state <= S_MUL;
        S_MUL:  state <= S_ADD;
        S_ADD: begin
          state <= S_ITER;
          cnt   <= '0;
        end
        S_ITER: begin
          cnt <= cnt + 5'd1;
          if (cnt == STEPS - 5'd1) state <= S_UPD;
        end
        S_UPD: begin
          if (fwd_dist < look_ahead && dist_ok && on_road &&
              (!seen[lane] || near_dist[lane] > fwd_dist)) begin
            seen[lane] <= 1'b1;
          end
          k     <= '0;
          state <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: if (out_free) begin
          k <= k + 3'd1;
          if (last_k) begin
            seen  <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath: capture, squares, serial steps, store
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_ch.valid) begin
        diff <= {1'b0, in_ch.track_position} - {1'b0, ego_position};
        off  <= in_ch.lateral_offset;
        vx   <= in_ch.vel_x;
        vy   <= in_ch.vel_y;
        last <= in_ch.last_track;
      end
      S_MUL: begin
        px   <= 28'(vx) * 28'(vx);
        py   <= 28'(vy) * 28'(vy);
        md_a <= mag;
        md_r <= '0;
        ld_n <= off;
        ld_r <= '0;
        ld_q <= '0;
      end
      S_ADD: begin
        sq_rad  <= px + py;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      S_ITER: begin
        md_a <= {md_a[18:0], 1'b0};
        md_r <= (md_t >= {1'b0, loop_len}) ? 20'(md_t - {1'b0, loop_len})
                                           : md_t[19:0];
        if (cnt < DIV_STEPS) begin
          ld_n <= {ld_n[14:0], 1'b0};
          ld_q <= {ld_q[14:0], ld_t >= {1'b0, lane_span}};
          ld_r <= (ld_t >= {1'b0, lane_span}) ? 12'(ld_t - {1'b0, lane_span})
                                              : ld_t[11:0];
        end
        if (cnt < SQ_STEPS) begin
          sq_rad  <= {sq_rad[25:0], 2'b00};
          sq_rem  <= (sq_t >= sq_trial) ? 15'(sq_t - sq_trial) : sq_t[14:0];
          sq_root <= {sq_root[12:0], sq_t >= sq_trial};
        end
      end
      S_UPD: begin
        if (fwd_dist < look_ahead && dist_ok && on_road &&
            (!seen[lane] || near_dist[lane] > fwd_dist)) begin
          near_dist[lane] <= fwd_dist;
          near_spd[lane]  <= sq_root;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_ch.lane_index     <= k;
      out_ch.blocked        <= seen[k];
      out_ch.block_distance <= seen[k] ? near_dist[k] : '0;
      out_ch.exit_speed     <= seen[k] ? near_spd[k] : speed_limit;
      out_ch.last_lane      <= last_k;
    end
  end

  // checks
  a_iter_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER && cnt == STEPS - 5'd1) |=> state == S_UPD)
    else $error("serial steps did not end in update");
  a_last_lane: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_lane) |-> out_ch.lane_index == 3'(lanes - 4'd1))
    else $error("last lane flag on wrong lane");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item taken while busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && last_k) |=> seen == '0)
    else $error("store not cleared at frame end");

endmodule
